FILE: src/wpc_pkg.sv
package wpc_pkg;

  localparam int WINDOW_LEN_DEF = 64;
  localparam int REACH          = 3;
  localparam int WIN_CNT        = 2 * REACH + 1;
  localparam int VAL_W          = 24;
  localparam int GAP_W          = 6;
  localparam int CNT_W          = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 2'd2;

  localparam logic [VAL_W-1:0] THRESHOLD_RST = '0;
  localparam logic [GAP_W-1:0] MIN_GAP_RST   = 6'd1;
  localparam logic [GAP_W-1:0] MAX_GAP_RST   = 6'd63;
  localparam logic [CNT_W-1:0] CNT_MAX       = 6'd63;

  typedef struct packed {
    logic [VAL_W-1:0] threshold;
    logic [GAP_W-1:0] min_gap;
    logic [GAP_W-1:0] max_gap;
  } wpc_cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             full;
  } wpc_item_t;

endpackage

FILE: src/wpc_in_if.sv
interface wpc_in_if;
  import wpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] new_value;

  modport source (output valid, output new_value, input ready);
  modport sink   (input valid, input new_value, output ready);
endinterface

FILE: src/wpc_out_if.sv
interface wpc_out_if;
  import wpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] peak_count;
  logic             spacing_failed;

  modport source (output valid, output peak_count, output spacing_failed, input ready);
  modport sink   (input valid, input peak_count, input spacing_failed, output ready);
endinterface

FILE: src/wpc_front.sv
module wpc_front #(
  parameter int WINDOW_LEN = wpc_pkg::WINDOW_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wpc_in_if.sink            in_ch,
  output logic              push_valid,
  output wpc_pkg::wpc_item_t push_item,
  input  logic              push_ready
);
  import wpc_pkg::*;

  localparam int PW = $clog2(WINDOW_LEN + 1);
  localparam logic [PW-1:0] LEN_P = PW'(WINDOW_LEN);

  logic [PW-1:0] fill_r;
  logic          accept;

  assign in_ch.ready     = push_ready;
  assign accept          = in_ch.valid && push_ready;
  assign push_valid      = in_ch.valid;
  assign push_item.value = in_ch.new_value;
  // window is full once this item lands
  assign push_item.full  = (fill_r >= (LEN_P - PW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept && (fill_r != LEN_P)) begin
      fill_r <= fill_r + PW'(1);
    end
  end

endmodule

FILE: src/wpc_queue.sv
module wpc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  wpc_pkg::wpc_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output wpc_pkg::wpc_item_t pop_item,
  input  logic               pop_ready
);
  import wpc_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QAW-1:0] PTR_LAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] CNT_FULL = QCW'(QUEUE_DEPTH);

  wpc_item_t      slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

endmodule

FILE: src/wpc_back.sv
module wpc_back #(
  parameter int WINDOW_LEN = wpc_pkg::WINDOW_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wpc_pkg::wpc_cfg_t  cfg,
  input  logic               q_valid,
  input  wpc_pkg::wpc_item_t q_item,
  output logic               q_ready,
  wpc_out_if.source          out_ch
);
  import wpc_pkg::*;

  localparam int AW    = $clog2(WINDOW_LEN);
  localparam int PW    = $clog2(WINDOW_LEN + 1);
  localparam int GW    = (PW > GAP_W) ? PW : GAP_W;
  localparam int SUM_W = VAL_W + AW;
  localparam logic [PW-1:0]    LEN_P    = PW'(WINDOW_LEN);
  localparam logic [AW-1:0]    ADDR_TOP = AW'(WINDOW_LEN - 1);
  localparam logic [SUM_W-1:0] LEN_S    = SUM_W'(WINDOW_LEN);
  localparam logic [PW-1:0]    WIN_P    = PW'(WIN_CNT);
  localparam logic [PW-1:0]    CTR_OFS  = PW'(REACH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_PEAK, S_RESULT} state_t;

  logic [VAL_W-1:0] mem [WINDOW_LEN];
  logic [VAL_W-1:0] rd_data_r;

  state_t           state_r;
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    base_r;
  logic [AW-1:0]    addr_r;
  logic [PW-1:0]    k_r;
  logic [PW-1:0]    rx_r;
  logic             rd_vld_r;
  logic             eval_r;
  logic [SUM_W-1:0] sum_r;
  logic [VAL_W-1:0] win_r [WIN_CNT];
  logic [PW-1:0]    cnt_r;
  logic [PW-1:0]    last_r;
  logic             fail_r;
  logic             out_vld_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_fail_r;

  logic             rd_en;
  logic             mem_we;
  logic [AW-1:0]    addr_dec;
  logic [AW-1:0]    wp_nxt;
  logic [SUM_W-1:0] prod;
  logic             nb_ok;
  logic             peak_hit;
  logic [PW-1:0]    ctr_pos;
  logic [GW-1:0]    gap;
  logic             gap_bad;
  logic [GW-1:0]    cnt_ext;
  logic             reject;
  logic [CNT_W-1:0] cnt_sat;

  assign q_ready  = (state_r == S_IDLE);
  assign mem_we   = q_valid && q_ready;
  assign rd_en    = ((state_r == S_SUM) || (state_r == S_PEAK)) && (k_r != LEN_P);
  assign addr_dec = (addr_r == '0) ? ADDR_TOP : addr_r - AW'(1);
  assign wp_nxt   = (wp_r == ADDR_TOP) ? '0 : wp_r + AW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= q_item.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // peak test on the center of the seven-value neighborhood
  always_comb begin
    nb_ok = 1'b1;
    for (int i = 0; i < WIN_CNT; i++) begin
      if (win_r[i] > win_r[REACH]) begin
        nb_ok = 1'b0;
      end
    end
  end

  assign prod     = SUM_W'(win_r[REACH]) * LEN_S;
  assign ctr_pos  = rx_r - CTR_OFS;
  assign peak_hit = (state_r == S_PEAK) && eval_r && (rx_r >= WIN_P) && nb_ok &&
                    (win_r[REACH] >= cfg.threshold) && (prod >= sum_r);
  assign gap      = GW'(ctr_pos - last_r);
  assign gap_bad  = (gap < GW'(cfg.min_gap)) || (gap > GW'(cfg.max_gap));

  assign cnt_ext  = GW'(cnt_r);
  assign reject   = (cnt_r > PW'(1)) && fail_r;
  assign cnt_sat  = (cnt_ext > GW'(CNT_MAX)) ? CNT_MAX : cnt_ext[CNT_W-1:0];

  assign out_ch.valid          = out_vld_r;
  assign out_ch.peak_count     = out_cnt_r;
  assign out_ch.spacing_failed = out_fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      k_r       <= '0;
      rx_r      <= '0;
      rd_vld_r  <= 1'b0;
      eval_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      eval_r   <= 1'b0;
      if (out_vld_r && out_ch.ready && (state_r != S_RESULT)) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            wp_r    <= wp_nxt;
            base_r  <= wp_r;
            addr_r  <= wp_r;
            k_r     <= '0;
            rx_r    <= '0;
            sum_r   <= '0;
            cnt_r   <= '0;
            last_r  <= '0;
            fail_r  <= 1'b0;
            state_r <= q_item.full ? S_SUM : S_RESULT;
          end
        end
        S_SUM: begin
          if (rd_en) begin
            addr_r <= addr_dec;
            k_r    <= k_r + PW'(1);
          end
          if (rd_vld_r) begin
            sum_r <= sum_r + SUM_W'(rd_data_r);
          end
          if ((k_r == LEN_P) && !rd_vld_r) begin
            k_r     <= '0;
            addr_r  <= base_r;
            state_r <= S_PEAK;
          end
        end
        S_PEAK: begin
          if (rd_en) begin
            addr_r <= addr_dec;
            k_r    <= k_r + PW'(1);
          end
          if (rd_vld_r) begin
            win_r[0] <= rd_data_r;
            for (int i = 1; i < WIN_CNT; i++) begin
              win_r[i] <= win_r[i-1];
            end
            rx_r   <= rx_r + PW'(1);
            eval_r <= 1'b1;
          end
          if (peak_hit) begin
            if ((cnt_r != '0) && gap_bad) begin
              fail_r <= 1'b1;
            end
            last_r <= ctr_pos;
            cnt_r  <= cnt_r + PW'(1);
          end
          if ((k_r == LEN_P) && !rd_vld_r && !eval_r) begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_vld_r || out_ch.ready) begin
            out_vld_r  <= 1'b1;
            out_cnt_r  <= reject ? '0 : cnt_sat;
            out_fail_r <= reject;
            state_r    <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= LEN_P) else $error("read issue count past window length");

  a_rx_behind_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEAK) |-> (rx_r <= k_r)) else $error("received more reads than issued");

  a_fail_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_fail_r) |-> (out_cnt_r == '0))
    else $error("spacing failure with nonzero count");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(wp_r)) else $error("ring written while scanning");
`endif

endmodule

FILE: src/windowed_peak_counter.sv
// channel   dir   handshake            payload
// in_ch     in    valid/ready          new_value[23:0]
// out_ch    out   valid/ready          peak_count[5:0], spacing_failed
// cfg_*     in    cfg_we (no stall)    cfg_index[1:0], cfg_wdata[23:0]
//
// item before the window is full: the queue registers it on input accept, and from
//   the queue head it goes straight to S_RESULT, which registers the result
// full window: from the queue head, two passes over the ring
//   (sum, then peak scan) through its single read port
// reset clears control and config; ring contents are undefined until written
// a two-item queue takes input while the back end scans; the result register
//   holds its item until out_ch takes it
module windowed_peak_counter #(
  parameter int WINDOW_LEN = wpc_pkg::WINDOW_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wpc_in_if.sink                         in_ch,
  wpc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpc_pkg::VAL_W-1:0]      cfg_wdata
);
  import wpc_pkg::*;

  wpc_cfg_t  cfg_r;
  logic      push_valid;
  wpc_item_t push_item;
  logic      push_ready;
  logic      q_valid;
  wpc_item_t q_item;
  logic      q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.min_gap   <= MIN_GAP_RST;
      cfg_r.max_gap   <= MAX_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg_r.threshold <= cfg_wdata;
        REG_MIN_GAP:   cfg_r.min_gap   <= cfg_wdata[GAP_W-1:0];
        REG_MAX_GAP:   cfg_r.max_gap   <= cfg_wdata[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wpc_front #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  wpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  wpc_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/windowed_peak_counter_tb.sv
module windowed_peak_counter_tb;
  import wpc_pkg::*;

  localparam int WIN = WINDOW_LEN_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * WIN + 20;
  localparam int RANDOM_ITEMS = 650;

  typedef enum int {SHAPE_UNIFORM, SHAPE_SPIKES, SHAPE_TIES, SHAPE_SPARSE} shape_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             failed;
  } peak_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0] cfg_wdata;

  wpc_in_if in_ch ();
  wpc_out_if out_ch ();

  windowed_peak_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // sample ring and register copies
  logic [VAL_W-1:0] ring [WIN];
  int fill_cnt;
  int wr_slot;
  logic [VAL_W-1:0] thr_reg;
  logic [GAP_W-1:0] min_gap_reg;
  logic [GAP_W-1:0] max_gap_reg;

  peak_result_t results_due[$];
  int errors;
  int quiet;
  bit gaps_on;

  always #2 clk = ~clk;

  function automatic void count_peaks(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] snap [WIN];
    longint total;
    int peaks;
    int last;
    int p;
    int q;
    bit bad;
    bit is_top;
    peak_result_t r;
    ring[wr_slot] = v;
    wr_slot = (wr_slot + 1) % WIN;
    if (fill_cnt < WIN) fill_cnt++;
    r = '0;
    if (fill_cnt == WIN) begin
      total = 0;
      peaks = 0;
      last = 0;
      bad = 1'b0;
      // position 0 is the newest sample
      for (p = 0; p < WIN; p++) begin
        snap[p] = ring[(wr_slot + WIN - 1 - p) % WIN];
        total += snap[p];
      end
      for (p = REACH; p + REACH < WIN; p++) begin
        is_top = (snap[p] >= thr_reg) && (longint'(snap[p]) * WIN >= total);
        for (q = p - REACH; q <= p + REACH; q++) begin
          if (snap[q] > snap[p]) is_top = 1'b0;
        end
        if (is_top) begin
          if (peaks > 0 && ((p - last) < min_gap_reg || (p - last) > max_gap_reg)) bad = 1'b1;
          last = p;
          peaks++;
        end
      end
      if (peaks > 1 && bad) begin
        r.failed = 1'b1;
      end else begin
        r.count = (peaks > CNT_MAX) ? CNT_MAX : CNT_W'(peaks);
      end
    end
    results_due = {results_due, r};
  endfunction

  function automatic logic [VAL_W-1:0] shape_value(input shape_t shape, input int i,
                                                   input int period);
    logic [VAL_W-1:0] v;
    case (shape)
      SHAPE_SPIKES: begin
        if ($urandom_range(0, 15) == 0) v = VAL_W'($urandom_range(0, 24'hFFFFFF));
        else if (i % period == 0) v = VAL_W'($urandom_range(24'h800000, 24'hFFFFFF));
        else v = VAL_W'($urandom_range(0, 24'h0000FF));
      end
      SHAPE_TIES: v = VAL_W'($urandom_range(0, 2));
      SHAPE_SPARSE: v = ($urandom_range(0, 39) == 0) ? VAL_W'($urandom_range(1, 24'hFFFFFF)) : '0;
      default: v = VAL_W'($urandom_range(0, 24'hFFFFFF));
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [VAL_W-1:0] v);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.new_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    count_peaks(v);
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (results_due.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_THRESHOLD: thr_reg = data;
      REG_MIN_GAP: min_gap_reg = data[GAP_W-1:0];
      REG_MAX_GAP: max_gap_reg = data[GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [VAL_W-1:0] thr, input logic [VAL_W-1:0] mn,
                          input logic [VAL_W-1:0] mx);
    quiesce();
    put_reg(REG_THRESHOLD, thr);
    put_reg(REG_MIN_GAP, mn);
    put_reg(REG_MAX_GAP, mx);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pair();
    send_value('0);
    send_value(24'hFFFFFF);
  endtask

  task automatic test_window_fill();
    int i;
    gaps_on = 1'b1;
    for (i = 0; i < WIN; i++) send_value((i % 2) ? 24'hFFFFFF : 24'h000000);
  endtask

  task automatic test_gap_limits();
    set_regs(24'd0, 24'd63, 24'd1);
    send_pair();
    set_regs(24'd0, 24'd0, 24'd2);
    send_pair();
    set_regs(24'd0, 24'd3, 24'd63);
    send_pair();
    set_regs(24'hFFFFFF, 24'd1, 24'd63);
    send_pair();
  endtask

  task automatic test_register_edges();
    quiesce();
    put_reg(REG_SPARE, 24'hFFFFFF);
    put_reg(REG_MIN_GAP, 24'hFFFFC2);
    put_reg(REG_MAX_GAP, 24'h000FC2);
    put_reg(REG_THRESHOLD, 24'hFFFFFE);
    cfg_we <= 1'b0;
    send_pair();
  endtask

  task automatic test_lone_spike();
    int i;
    set_regs(24'd1, 24'd1, 24'd63);
    for (i = 0; i < WIN; i++) begin
      send_value((i == 30) ? VAL_W'($urandom_range(1, 24'hFFFFFF)) : '0);
    end
  endtask

  task automatic test_random_shapes();
    int sent;
    int i;
    int n;
    int period;
    shape_t shape;
    logic [VAL_W-1:0] thr;
    logic [VAL_W-1:0] mn;
    logic [VAL_W-1:0] mx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      shape = shape_t'($urandom_range(0, 3));
      period = $urandom_range(1, 12);
      n = $urandom_range(40, 120);
      case ($urandom_range(0, 3))
        0: thr = '0;
        1: thr = 24'hFFFFFF;
        2: thr = VAL_W'($urandom_range(0, 24'h0000FF));
        default: thr = VAL_W'($urandom_range(0, 24'hFFFFFF));
      endcase
      mn = ($urandom_range(0, 4) == 0) ? VAL_W'($urandom_range(0, 63)) :
                                         VAL_W'($urandom_range(0, 4));
      case ($urandom_range(0, 2))
        0: mx = VAL_W'($urandom_range(0, 63));
        1: mx = VAL_W'(period + $urandom_range(0, 2));
        default: mx = VAL_W'($urandom_range(8, 63));
      endcase
      set_regs(thr, mn, mx);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < n; i++) send_value(shape_value(shape, i, period));
      sent += n;
    end
  endtask

  task automatic test_back_to_back();
    int i;
    int period;
    set_regs(24'd0, 24'd1, 24'd63);
    gaps_on = 1'b0;
    period = $urandom_range(2, 8);
    for (i = 0; i < 120; i++) begin
      send_value(shape_value((i < 60) ? SHAPE_SPIKES : SHAPE_UNIFORM, i, period));
    end
  endtask

  // result side stalls
  initial begin : sink_side
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && gaps_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 9);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    peak_result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t unexpected item: expected none, actual count %0d failed %0b", $time,
                 out_ch.peak_count, out_ch.spacing_failed);
      end else begin
        due = results_due.pop_front();
        if (out_ch.peak_count !== due.count) begin
          errors++;
          $display("%0t peak_count: expected %0d, actual %0d", $time, due.count,
                   out_ch.peak_count);
        end
        if (out_ch.spacing_failed !== due.failed) begin
          errors++;
          $display("%0t spacing_failed: expected %0b, actual %0b", $time, due.failed,
                   out_ch.spacing_failed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("[windowed_peak_counter] ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.new_value = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    errors = 0;
    quiet = 0;
    gaps_on = 1'b1;
    fill_cnt = 0;
    wr_slot = 0;
    thr_reg = THRESHOLD_RST;
    min_gap_reg = MIN_GAP_RST;
    max_gap_reg = MAX_GAP_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_window_fill();
    test_gap_limits();
    test_register_edges();
    test_lone_spike();
    test_random_shapes();
    test_back_to_back();
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[windowed_peak_counter] OK");
    end else begin
      $display("[windowed_peak_counter] ERROR");
    end
    $finish;
  end

endmodule
